FILE: sv/acc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_pkg
// Types, codes and digit helpers shared by the alarm clock controller.
// ----------------------------------------------------------------------------
package acc_pkg;

  localparam logic [7:0] TICKS_PER_SECOND_RESET = 8'd50;
  localparam logic [5:0] SECOND_MAX  = 6'd59;
  localparam logic [5:0] MINUTE_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [5:0] TENS_WRAP   = 6'd50;
  localparam logic [5:0] TENS_STEP   = 6'd10;
  localparam logic [5:0] ONES_WRAP   = 6'd9;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_HOLD    = 2'd2;

  localparam logic [1:0] KEY_MODE   = 2'd0;
  localparam logic [1:0] KEY_CHANGE = 2'd2;

  localparam logic [1:0] CUR_HOUR        = 2'd0;
  localparam logic [1:0] CUR_MINUTE_TENS = 2'd1;
  localparam logic [1:0] CUR_MINUTE_ONES = 2'd2;

  typedef enum logic [1:0] {
    RUN_CLOCK     = 2'd0,
    RUN_EDIT_TIME = 2'd1,
    RUN_EDIT_WAKE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] key_id;
    logic       alarm_enable;
  } item_t;

  typedef struct packed {
    logic [1:0] run_mode;
    logic [1:0] cursor;
    logic [4:0] display_hour;
    logic [5:0] display_minute;
    logic [5:0] display_second;
    logic       seconds_shown;
    logic       beep_on;
    logic       second_edge;
  } result_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } hm_t;

  typedef struct packed {
    logic [7:0] tick_count;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [5:0] clock_second;
    hm_t        pending;
    hm_t        wake;
    mode_t      mode;
    logic [1:0] cursor;
    logic       beeping;
  } acc_state_t;

  function automatic logic ones_is_nine(logic [5:0] m);
    logic r;
    case (m) inside
      6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59: r = 1'b1;
      default:                                 r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic hm_t step_digit(hm_t t, logic [1:0] pos);
    hm_t r;
    r = t;
    case (pos)
      CUR_HOUR:        r.hour = (t.hour >= HOUR_MAX) ? 5'd0 : t.hour + 5'd1;
      CUR_MINUTE_TENS: r.minute = (t.minute >= TENS_WRAP) ? t.minute - TENS_WRAP
                                                          : t.minute + TENS_STEP;
      CUR_MINUTE_ONES: r.minute = ones_is_nine(t.minute) ? t.minute - ONES_WRAP
                                                         : t.minute + 6'd1;
      default:         r = t;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/acc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_in_if
// Input item channel: tick or key event, valid/ready handshake.
// ----------------------------------------------------------------------------
interface acc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] key_id;
  logic       alarm_enable;

  modport source (output valid, func, key_id, alarm_enable, input ready);
  modport sink   (input valid, func, key_id, alarm_enable, output ready);
endinterface

FILE: sv/acc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_out_if
// Result channel: display values per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface acc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] run_mode;
  logic [1:0] cursor;
  logic [4:0] display_hour;
  logic [5:0] display_minute;
  logic [5:0] display_second;
  logic       seconds_shown;
  logic       beep_on;
  logic       second_edge;

  modport source (output valid, run_mode, cursor, display_hour, display_minute,
                  display_second, seconds_shown, beep_on, second_edge,
                  input ready);
  modport sink   (input valid, run_mode, cursor, display_hour, display_minute,
                  display_second, seconds_shown, beep_on, second_edge,
                  output ready);
endinterface

FILE: sv/alarm_clock_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_controller
// hh:mm:ss alarm clock driven by tick and key items, one result per item.
// ----------------------------------------------------------------------------
// Pipeline: each item passes an input register, then a result register.
// Throughput: one item per cycle while the result sink takes each result; the
//   state update is combinational and is registered when the item advances.
// Reset (rst, synchronous): clock, pending and alarm times to 00:00, normal
//   mode, cursor on hour, alarm silent, ticks_per_second to 50.
module alarm_clock_controller (
  input  logic              clk,
  input  logic              rst,
  acc_in_if.sink            item,
  acc_out_if.source         result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);
  import acc_pkg::*;

  logic       [7:0] ticks_per_second;
  item_t            in_item;
  logic             in_valid;
  acc_state_t       state;
  acc_state_t       state_next;
  result_t          res_next;
  result_t          res_reg;
  logic             res_valid;
  logic             advance;

  assign advance    = in_valid && (!res_valid || result.ready);
  assign item.ready = !in_valid || advance;

  acc_step u_step (
    .state            (state),
    .item             (in_item),
    .ticks_per_second (ticks_per_second),
    .state_next       (state_next),
    .result           (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TICKS_PER_SECOND_RESET;
      in_valid         <= 1'b0;
      res_valid        <= 1'b0;
      state            <= '0;
    end else begin
      if (cfg_we) ticks_per_second <= cfg_data;
      if (item.ready) in_valid <= item.valid;
      if (advance) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (item.valid && item.ready) begin
      in_item.func         <= item.func;
      in_item.key_id       <= item.key_id;
      in_item.alarm_enable <= item.alarm_enable;
    end
    if (advance) res_reg <= res_next;
  end

  assign result.valid          = res_valid;
  assign result.run_mode       = res_reg.run_mode;
  assign result.cursor         = res_reg.cursor;
  assign result.display_hour   = res_reg.display_hour;
  assign result.display_minute = res_reg.display_minute;
  assign result.display_second = res_reg.display_second;
  assign result.seconds_shown  = res_reg.seconds_shown;
  assign result.beep_on        = res_reg.beep_on;
  assign result.second_edge    = res_reg.second_edge;

  a_clock_second_range: assert property (@(posedge clk) disable iff (rst)
    state.clock_second <= SECOND_MAX)
    else $error("clock second out of range");

  a_edge_clears_count: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.second_edge |=> state.tick_count == 8'd0)
    else $error("tick count not cleared on second edge");

  a_beep_starts_on_edge: assert property (@(posedge clk) disable iff (rst)
    $rose(state.beeping) |-> $past(advance && res_next.second_edge))
    else $error("alarm started off a second edge");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && res_valid && !result.ready |-> !item.ready)
    else $error("input taken while pipeline stalled");

endmodule

FILE: sv/acc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_step
// Next-state and display logic for one tick or key event.
// ----------------------------------------------------------------------------
module acc_step (
  input  acc_pkg::acc_state_t state,
  input  acc_pkg::item_t      item,
  input  logic [7:0]          ticks_per_second,
  output acc_pkg::acc_state_t state_next,
  output acc_pkg::result_t    result
);
  import acc_pkg::*;

  logic [7:0] tick_inc;
  logic       edge_hit;
  logic [5:0] sec_adv;
  logic [5:0] min_adv;
  logic [4:0] hour_adv;
  mode_t      mode_adv;
  hm_t        shown;

  assign tick_inc = state.tick_count + 8'd1;
  assign edge_hit = (item.func == FUNC_TICK) && (tick_inc == ticks_per_second);

  always_comb begin
    sec_adv  = state.clock_second + 6'd1;
    min_adv  = state.clock_minute;
    hour_adv = state.clock_hour;
    if (state.clock_second >= SECOND_MAX) begin
      sec_adv = 6'd0;
      if (state.clock_minute >= MINUTE_MAX) begin
        min_adv  = 6'd0;
        hour_adv = (state.clock_hour >= HOUR_MAX) ? 5'd0 : state.clock_hour + 5'd1;
      end else begin
        min_adv = state.clock_minute + 6'd1;
      end
    end
  end

  assign mode_adv = (state.mode == RUN_CLOCK)     ? RUN_EDIT_TIME :
                    (state.mode == RUN_EDIT_TIME) ? RUN_EDIT_WAKE : RUN_CLOCK;

  always_comb begin
    state_next = state;
    case (item.func)
      FUNC_TICK: begin
        state_next.tick_count = tick_inc;
        if (edge_hit) begin
          state_next.tick_count   = 8'd0;
          state_next.clock_second = sec_adv;
          state_next.clock_minute = min_adv;
          state_next.clock_hour   = hour_adv;
          if (state.beeping) begin
            if (!item.alarm_enable) state_next.beeping = 1'b0;
          end else if (hour_adv == state.wake.hour && min_adv == state.wake.minute &&
                       sec_adv == 6'd0 && item.alarm_enable) begin
            state_next.beeping = 1'b1;
          end
        end
      end
      FUNC_RELEASE: begin
        if (item.key_id == KEY_MODE) begin
          state_next.mode   = mode_adv;
          state_next.cursor = CUR_HOUR;
          if (mode_adv == RUN_EDIT_TIME) begin
            state_next.pending.hour   = state.clock_hour;
            state_next.pending.minute = state.clock_minute;
          end
        end else if (item.key_id == KEY_CHANGE) begin
          if (state.mode == RUN_EDIT_TIME)
            state_next.pending = step_digit(state.pending, state.cursor);
          else if (state.mode == RUN_EDIT_WAKE)
            state_next.wake = step_digit(state.wake, state.cursor);
        end
      end
      FUNC_HOLD: begin
        if (item.key_id == KEY_MODE) begin
          state_next.cursor = (state.cursor >= CUR_MINUTE_ONES) ? CUR_HOUR
                                                                : state.cursor + 2'd1;
        end else if (item.key_id == KEY_CHANGE && state.mode == RUN_EDIT_TIME) begin
          state_next.mode         = RUN_CLOCK;
          state_next.clock_hour   = state.pending.hour;
          state_next.clock_minute = state.pending.minute;
          state_next.clock_second = 6'd0;
        end
      end
      default: state_next = state;
    endcase
  end

  always_comb begin
    case (state_next.mode)
      RUN_EDIT_TIME: shown = state_next.pending;
      RUN_EDIT_WAKE: shown = state_next.wake;
      default: begin
        shown.hour   = state_next.clock_hour;
        shown.minute = state_next.clock_minute;
      end
    endcase
  end

  always_comb begin
    result.run_mode       = state_next.mode;
    result.cursor         = state_next.cursor;
    result.display_hour   = shown.hour;
    result.display_minute = shown.minute;
    result.seconds_shown  = (state_next.mode == RUN_CLOCK);
    result.display_second = (state_next.mode == RUN_CLOCK) ? state_next.clock_second
                                                           : 6'd0;
    result.beep_on        = state_next.beeping;
    result.second_edge    = edge_hit;
  end

endmodule

FILE: dv/alarm_clock_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_controller_test
// Self-checking bench for the alarm clock controller. A behavioral copy of
// the tick divider, hh:mm:ss clock, key handling and alarm tracks every item
// transfer and predicts the display. Each result is checked field by field,
// in order. Directed key cases come first. Random traffic follows: time and
// alarm dialing, alarm firing and silencing, midnight wrap and noise items.
// It runs at several tick rates and under source gaps and sink stalls.
// ----------------------------------------------------------------------------
module alarm_clock_controller_test;
  import acc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;

  acc_in_if  in_ch ();
  acc_out_if out_ch ();

  alarm_clock_controller uut (
    .clk     (clk),
    .rst     (rst),
    .item    (in_ch),
    .result  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // predicted block state
  logic [7:0] rate;
  logic [7:0] tick_cnt;
  logic [4:0] now_hour;
  logic [5:0] now_min;
  logic [5:0] now_sec;
  hm_t        set_time;
  hm_t        wake_set;
  mode_t      run_state;
  logic [1:0] cur_pos;
  logic       ringing;

  result_t due_displays[$];
  result_t head;
  int      errors = 0;
  int      sent = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_displays.size() == 0) begin
        errors++;
        $error("result transfer with no expected display waiting");
      end else begin
        head = due_displays.pop_front();
        check_field("run_mode", 8'(head.run_mode), 8'(out_ch.run_mode));
        check_field("cursor", 8'(head.cursor), 8'(out_ch.cursor));
        check_field("display_hour", 8'(head.display_hour), 8'(out_ch.display_hour));
        check_field("display_minute", 8'(head.display_minute),
                    8'(out_ch.display_minute));
        check_field("display_second", 8'(head.display_second),
                    8'(out_ch.display_second));
        check_field("seconds_shown", 8'(head.seconds_shown), 8'(out_ch.seconds_shown));
        check_field("beep_on", 8'(head.beep_on), 8'(out_ch.beep_on));
        check_field("second_edge", 8'(head.second_edge), 8'(out_ch.second_edge));
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_model();
    rate       = TICKS_PER_SECOND_RESET;
    tick_cnt   = '0;
    now_hour   = '0;
    now_min    = '0;
    now_sec    = '0;
    set_time   = '0;
    wake_set   = '0;
    run_state  = RUN_CLOCK;
    cur_pos    = CUR_HOUR;
    ringing    = 1'b0;
  endfunction

  function automatic hm_t stepped(hm_t t, logic [1:0] pos);
    hm_t r;
    r = t;
    if (pos == CUR_HOUR) begin
      r.hour = (t.hour >= HOUR_MAX) ? 5'd0 : t.hour + 5'd1;
    end else if (pos == CUR_MINUTE_TENS) begin
      r.minute = (t.minute >= 6'd50) ? t.minute - 6'd50 : t.minute + 6'd10;
    end else if (pos == CUR_MINUTE_ONES) begin
      r.minute = (t.minute % 6'd10 == 6'd9) ? t.minute - 6'd9 : t.minute + 6'd1;
    end
    return r;
  endfunction

  function automatic result_t next_display(logic [1:0] func, logic [1:0] key, logic en);
    result_t r;
    logic    sec_tick;
    sec_tick = 1'b0;
    case (func)
      FUNC_TICK: begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt == rate) begin
          tick_cnt = '0;
          sec_tick = 1'b1;
          if (now_sec >= SECOND_MAX) begin
            now_sec = '0;
            if (now_min >= MINUTE_MAX) begin
              now_min  = '0;
              now_hour = (now_hour >= HOUR_MAX) ? 5'd0 : now_hour + 5'd1;
            end else begin
              now_min = now_min + 6'd1;
            end
          end else begin
            now_sec = now_sec + 6'd1;
          end
          if (ringing) begin
            if (!en) ringing = 1'b0;
          end else if (en && now_hour == wake_set.hour && now_min == wake_set.minute &&
                       now_sec == 6'd0) begin
            ringing = 1'b1;
          end
        end
      end
      FUNC_RELEASE: begin
        if (key == KEY_MODE) begin
          case (run_state)
            RUN_CLOCK:     run_state = RUN_EDIT_TIME;
            RUN_EDIT_TIME: run_state = RUN_EDIT_WAKE;
            default:       run_state = RUN_CLOCK;
          endcase
          cur_pos = CUR_HOUR;
          if (run_state == RUN_EDIT_TIME) begin
            set_time.hour   = now_hour;
            set_time.minute = now_min;
          end
        end else if (key == KEY_CHANGE) begin
          if (run_state == RUN_EDIT_TIME) set_time = stepped(set_time, cur_pos);
          else if (run_state == RUN_EDIT_WAKE) wake_set = stepped(wake_set, cur_pos);
        end
      end
      FUNC_HOLD: begin
        if (key == KEY_MODE) begin
          cur_pos = (cur_pos >= CUR_MINUTE_ONES) ? CUR_HOUR : cur_pos + 2'd1;
        end else if (key == KEY_CHANGE && run_state == RUN_EDIT_TIME) begin
          run_state = RUN_CLOCK;
          now_hour  = set_time.hour;
          now_min   = set_time.minute;
          now_sec   = '0;
        end
      end
      default: ;
    endcase
    r.run_mode = run_state;
    r.cursor   = cur_pos;
    case (run_state)
      RUN_EDIT_TIME: begin
        r.display_hour   = set_time.hour;
        r.display_minute = set_time.minute;
      end
      RUN_EDIT_WAKE: begin
        r.display_hour   = wake_set.hour;
        r.display_minute = wake_set.minute;
      end
      default: begin
        r.display_hour   = now_hour;
        r.display_minute = now_min;
      end
    endcase
    r.display_second = (run_state == RUN_CLOCK) ? now_sec : 6'd0;
    r.seconds_shown  = (run_state == RUN_CLOCK);
    r.beep_on        = ringing;
    r.second_edge    = sec_tick;
    return r;
  endfunction

  task automatic send(logic [1:0] func, logic [1:0] key, logic en);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= func;
    in_ch.key_id       <= key;
    in_ch.alarm_enable <= en;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    due_displays.push_back(next_display(func, key, en));
    sent++;
  endtask

  task automatic set_rate(logic [7:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate = value;
  endtask

  task automatic enter_mode(mode_t m);
    while (run_state != m) send(FUNC_RELEASE, KEY_MODE, 1'($urandom_range(1)));
  endtask

  // step the edited time to target, digit by digit
  task automatic dial(hm_t target);
    hm_t now;
    int  steps;
    now = (run_state == RUN_EDIT_TIME) ? set_time : wake_set;
    while (cur_pos != CUR_HOUR) send(FUNC_HOLD, KEY_MODE, 1'($urandom_range(1)));
    steps = (int'(target.hour) + 24 - int'(now.hour)) % 24;
    repeat (steps) send(FUNC_RELEASE, KEY_CHANGE, 1'($urandom_range(1)));
    send(FUNC_HOLD, KEY_MODE, 1'($urandom_range(1)));
    steps = (int'(target.minute) / 10 + 6 - int'(now.minute) / 10) % 6;
    repeat (steps) send(FUNC_RELEASE, KEY_CHANGE, 1'($urandom_range(1)));
    send(FUNC_HOLD, KEY_MODE, 1'($urandom_range(1)));
    steps = (int'(target.minute) % 10 + 10 - int'(now.minute) % 10) % 10;
    repeat (steps) send(FUNC_RELEASE, KEY_CHANGE, 1'($urandom_range(1)));
  endtask

  function automatic hm_t any_time();
    hm_t t;
    t.hour   = 5'($urandom_range(23));
    t.minute = 6'($urandom_range(59));
    return t;
  endfunction

  // set alarm, set clock one minute earlier, tick until it fires, then ring out
  task automatic fire_alarm();
    hm_t wake;
    hm_t start;
    int  guard;
    wake = ($urandom_range(3) == 0) ? hm_t'(0) : any_time();
    start = wake;
    if (wake.minute == 6'd0) begin
      start.minute = MINUTE_MAX;
      start.hour   = (wake.hour == 5'd0) ? HOUR_MAX : wake.hour - 5'd1;
    end else begin
      start.minute = wake.minute - 6'd1;
    end
    enter_mode(RUN_EDIT_WAKE);
    dial(wake);
    enter_mode(RUN_EDIT_TIME);
    dial(start);
    send(FUNC_HOLD, KEY_CHANGE, 1'($urandom_range(1)));
    guard = 0;
    while (!ringing && guard < 62 * 4) begin
      send(FUNC_TICK, 2'($urandom_range(3)), $urandom_range(19) != 0);
      guard++;
    end
    repeat ($urandom_range(2, 6) * int'(rate)) begin
      if ($urandom_range(9) == 0)
        send(2'($urandom_range(2)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      else send(FUNC_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
    end
  endtask

  task automatic random_traffic(int count, int tick_pct);
    int stop;
    int pick;
    stop = sent + count;
    while (sent < stop) begin
      pick = $urandom_range(99);
      if (pick < tick_pct) begin
        repeat ($urandom_range(1, (tick_pct > 50) ? 120 : 40))
          send(FUNC_TICK, 2'($urandom_range(3)), $urandom_range(4) != 0);
      end else if (pick < tick_pct + 20) begin
        enter_mode(RUN_EDIT_TIME);
        dial(any_time());
        if ($urandom_range(6) != 0) send(FUNC_HOLD, KEY_CHANGE, 1'($urandom_range(1)));
        else send(FUNC_RELEASE, KEY_MODE, 1'($urandom_range(1)));
      end else if (pick < tick_pct + 32) begin
        enter_mode(RUN_EDIT_WAKE);
        dial(any_time());
        send(FUNC_RELEASE, KEY_MODE, 1'($urandom_range(1)));
      end else if (pick < tick_pct + 50 && rate >= 8'd1 && rate <= 8'd3 && tick_cnt < rate) begin
        fire_alarm();
      end else begin
        repeat ($urandom_range(1, 6))
          send(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_key_actions();
    set_rate(8'd1);
    send(2'd3, 2'd3, 1'b1);
    send(FUNC_RELEASE, 2'd1, 1'b0);
    send(FUNC_RELEASE, 2'd3, 1'b1);
    send(FUNC_HOLD, 2'd1, 1'b0);
    send(FUNC_HOLD, 2'd3, 1'b1);
    send(FUNC_RELEASE, KEY_CHANGE, 1'b0);
    send(FUNC_HOLD, KEY_CHANGE, 1'b0);
    send(FUNC_HOLD, KEY_MODE, 1'b0);
    send(FUNC_RELEASE, KEY_MODE, 1'b0);
    send(FUNC_RELEASE, KEY_CHANGE, 1'b1);
    send(FUNC_HOLD, KEY_MODE, 1'b0);
    send(FUNC_RELEASE, KEY_CHANGE, 1'b0);
    send(FUNC_HOLD, KEY_MODE, 1'b1);
    send(FUNC_RELEASE, KEY_CHANGE, 1'b0);
    send(FUNC_HOLD, KEY_MODE, 1'b0);
    send(FUNC_HOLD, KEY_CHANGE, 1'b1);
    send(FUNC_TICK, KEY_MODE, 1'b1);
    send(FUNC_TICK, 2'd3, 1'b0);
    send(FUNC_RELEASE, KEY_MODE, 1'b0);
    send(FUNC_RELEASE, KEY_MODE, 1'b1);
    send(FUNC_HOLD, KEY_CHANGE, 1'b1);
    send(FUNC_RELEASE, KEY_CHANGE, 1'b0);
    send(FUNC_RELEASE, KEY_MODE, 1'b0);
  endtask

  task automatic test_sink_stalls();
    send_idle_pct = 38;
    recv_idle_pct = 66;
    set_rate(8'd1);
    random_traffic(300, 25);
    set_rate(8'd255);
    random_traffic(150, 85);
  endtask

  // count is usually above the new rate here and wraps through 255
  task automatic test_source_gaps();
    send_idle_pct = 66;
    recv_idle_pct = 38;
    set_rate(8'd3);
    random_traffic(300, 25);
    set_rate(8'd0);
    random_traffic(150, 85);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_rate(8'd2);
    random_traffic(200, 25);
    set_rate(TICKS_PER_SECOND_RESET);
    random_traffic(50, 60);
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_TICK;
    in_ch.key_id       <= KEY_MODE;
    in_ch.alarm_enable <= 1'b0;
    clear_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_key_actions();
    test_sink_stalls();
    test_source_gaps();
    test_full_rate();
    in_ch.valid <= 1'b0;
    while (due_displays.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
